// ===== src/kpvf_pkg.sv =====
// shared types, codes and defaults for the position/velocity kalman filter
package kpvf_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_BITS      = 31;
  localparam int CFG_IDX_BITS  = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEAS_NOISE    = 2'd2;

  // 1.0 in unsigned q15.16
  localparam logic [CFG_BITS-1:0] CFG_RESET = 31'd65536;

  typedef struct packed {
    logic               start_req;
    logic signed [31:0] sample;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } est_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_CFG, OP_CAPTURE, OP_LOAD,
    OP_N0, OP_N1, OP_N2, OP_N3, OP_N4, OP_N5, OP_N6,
    OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7,
    OP_DIVA, OP_DIVB, OP_K1,
    OP_E0, OP_E1, OP_E2, OP_E3, OP_E4, OP_E5, OP_E6,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_N0, ST_N1, ST_N2, ST_N3, ST_N4, ST_N5, ST_N6,
    ST_SEL,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_SCHK, ST_DIV0, ST_DIV1,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic load_req;
    logic s_zero;
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/kpvf_div.sv =====
// restoring divider: round((a << frac) / b), half away from zero, saturated
module kpvf_div import kpvf_pkg::*; #(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] quo
);

  localparam int CNTW = $clog2(W + F + 1);
  localparam logic [W+1:0] CAP   = (W + 2)'(1) << W;
  localparam logic [W+1:0] LIM_P = ((W + 2)'(1) << (W - 1)) - (W + 2)'(1);
  localparam logic [W+1:0] LIM_N = (W + 2)'(1) << (W - 1);

  logic            busy;
  logic            fin;
  logic [CNTW-1:0] cnt;
  logic [W+F-1:0]  sh;
  logic [W-1:0]    y;
  logic [W:0]      r;
  logic [W:0]      q;
  logic            neg;

  logic [W:0]      rs;
  logic            qb;
  logic [W+1:0]    qn;
  logic [W+1:0]    qr;
  logic [W+1:0]    qs;
  logic [W-1:0]    xa;
  logic [W-1:0]    ya;

  // operand magnitudes
  assign xa = num[W-1] ? W'(-num) : W'(num);
  assign ya = den[W-1] ? W'(-den) : W'(den);

  // one quotient bit per cycle
  always_comb begin
    rs = {r[W-1:0], sh[W+F-1]};
    qb = (rs >= {1'b0, y});
    qn = {q, qb};
    if (qn > CAP) begin
      qn = CAP;
    end
  end

  // final rounding and saturation
  always_comb begin
    qr = {1'b0, q} + (W + 2)'(r >= ({1'b0, y} - r));
    qs = qr;
    if (neg && qs > LIM_N) begin
      qs = LIM_N;
    end else if (!neg && qs > LIM_P) begin
      qs = LIM_P;
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W + F);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= {xa, {F{1'b0}}};
      y   <= ya;
      r   <= '0;
      q   <= '0;
      neg <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      sh <= sh << 1;
      r  <= qb ? rs - {1'b0, y} : rs;
      q  <= qn[W:0];
    end else if (fin) begin
      quo <= neg ? -$signed(qs[W-1:0]) : $signed(qs[W-1:0]);
    end
  end

endmodule

// ===== src/kpvf_dp.sv =====
// filter datapath: state, covariance, shared multiplier and divider
module kpvf_dp import kpvf_pkg::*; #(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  meas_t                   meas,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output est_t                    est
);

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] ONE  = W'(1) << F;
  localparam logic signed [W:0] WMAX_E = {2'b00, {(W - 1){1'b1}}};
  localparam logic signed [W:0] WMIN_E = {2'b11, {(W - 1){1'b0}}};
  localparam logic [2*W:0] HALF  = (2 * W + 1)'(1) << (F - 1);
  localparam logic [2*W:0] LIM_P = ((2 * W + 1)'(1) << (W - 1)) - (2 * W + 1)'(1);
  localparam logic [2*W:0] LIM_N = (2 * W + 1)'(1) << (W - 1);
  localparam int XW = (W > 31) ? W + 1 : 32;
  localparam int ZW = (W > 32) ? W + 1 : 33;

  logic [CFG_BITS-1:0] dt_reg, q_reg, r_reg;
  logic signed [W-1:0] pos, vel, p0, p1, p2, p3;
  logic signed [W-1:0] q00, q01, q11;
  logic signed [W-1:0] m, t0, t1, t2, t3;
  logic signed [W-1:0] z, s, y, k0, k1;
  logic                st, primed;
  logic signed [W-1:0] dt, qn, rn, zc;
  logic                div_start, div_done;
  logic signed [W-1:0] div_num, quo;
  logic signed [ZW-1:0] sx;

  function automatic logic signed [W-1:0] satw(input logic signed [W:0] v);
    logic signed [W-1:0] res;
    begin
      if (v > WMAX_E) begin
        res = WMAX;
      end else if (v < WMIN_E) begin
        res = WMIN_E[W-1:0];
      end else begin
        res = v[W-1:0];
      end
      return res;
    end
  endfunction

  function automatic logic signed [W-1:0] addw(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] v;
    begin
      v = $signed({a[W-1], a}) + $signed({b[W-1], b});
      return satw(v);
    end
  endfunction

  function automatic logic signed [W-1:0] subw(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] v;
    begin
      v = $signed({a[W-1], a}) - $signed({b[W-1], b});
      return satw(v);
    end
  endfunction

  function automatic logic signed [W-1:0] mulw(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic [W-1:0]   x, u, mg;
    logic [2*W-1:0] p;
    logic [2*W:0]   pr;
    logic           ng;
    begin
      x  = a[W-1] ? W'(-a) : W'(a);
      u  = b[W-1] ? W'(-b) : W'(b);
      p  = x * u;
      pr = ({1'b0, p} + HALF) >> F;
      ng = a[W-1] ^ b[W-1];
      if (ng && pr > LIM_N) begin
        pr = LIM_N;
      end else if (!ng && pr > LIM_P) begin
        pr = LIM_P;
      end
      mg = pr[W-1:0];
      return ng ? $signed(-mg) : $signed(mg);
    end
  endfunction

  function automatic logic signed [W-1:0] regw(input logic [CFG_BITS-1:0] v);
    logic [XW-1:0] ve;
    begin
      ve = XW'(v);
      return (ve > XW'(WMAX)) ? WMAX : $signed(ve[W-1:0]);
    end
  endfunction

  function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
    logic signed [ZW-1:0] ve;
    logic signed [31:0]   res;
    begin
      ve = ZW'(v);
      if (ve > ZW'(33'sh0_7FFF_FFFF)) begin
        res = 32'sh7FFF_FFFF;
      end else if (ve < ZW'(-33'sh0_8000_0000)) begin
        res = 32'sh8000_0000;
      end else begin
        res = ve[31:0];
      end
      return res;
    end
  endfunction

  // register values as words
  assign dt = regw(dt_reg);
  assign qn = regw(q_reg);
  assign rn = regw(r_reg);

  // incoming sample clamped to the word
  always_comb begin
    sx = ZW'(meas.sample);
    if (sx > ZW'(WMAX)) begin
      zc = WMAX;
    end else if (sx < ZW'(WMIN_E)) begin
      zc = WMIN_E[W-1:0];
    end else begin
      zc = sx[W-1:0];
    end
  end

  // divider hookup
  assign div_start = (cmd.op == OP_DIVA) || (cmd.op == OP_DIVB);
  assign div_num   = (cmd.op == OP_DIVA) ? p0 : p2;

  kpvf_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s),
    .done  (div_done),
    .quo   (quo)
  );

  assign status.load_req = st || !primed;
  assign status.s_zero   = (s == '0);
  assign status.div_done = div_done;

  // configuration registers and primed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dt_reg <= CFG_RESET;
      q_reg  <= CFG_RESET;
      r_reg  <= CFG_RESET;
      primed <= 1'b0;
    end else begin
      if (cmd.op == OP_CFG) begin
        if (cfg_index == REG_TIME_STEP) begin
          dt_reg <= cfg_data;
        end else if (cfg_index == REG_PROCESS_NOISE) begin
          q_reg <= cfg_data;
        end else if (cfg_index == REG_MEAS_NOISE) begin
          r_reg <= cfg_data;
        end
      end
      if (cmd.op == OP_N6) begin
        primed <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
        primed <= 1'b1;
      end
    end
  end

  // micro-operation execution
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_N0: m <= mulw(dt, dt);
      OP_N1: begin
        t2 <= m;
        m  <= mulw(m, dt);
      end
      OP_N2: begin
        t3 <= m;
        m  <= mulw(m, dt);
      end
      OP_N3: m <= mulw(qn, m);
      OP_N4: begin
        q00 <= W'(($signed({m[W-1], m}) + (W + 1)'(2)) >>> 2);
        m   <= mulw(qn, t3);
      end
      OP_N5: begin
        q01 <= W'(($signed({m[W-1], m}) + (W + 1)'(1)) >>> 1);
        m   <= mulw(qn, t2);
      end
      OP_N6: begin
        q11 <= m;
        pos <= '0;
        vel <= '0;
        p0  <= ONE;
        p1  <= '0;
        p2  <= '0;
        p3  <= ONE;
      end
      OP_CAPTURE: begin
        z  <= zc;
        st <= meas.start_req;
      end
      OP_LOAD: begin
        pos <= z;
        vel <= '0;
        p0  <= ONE;
        p1  <= '0;
        p2  <= '0;
        p3  <= ONE;
      end
      // predict
      OP_P0: m <= mulw(dt, vel);
      OP_P1: begin
        pos <= addw(pos, m);
        m   <= mulw(dt, p2);
      end
      OP_P2: begin
        t0 <= addw(p0, m);
        m  <= mulw(dt, p3);
      end
      OP_P3: begin
        t1 <= addw(p1, m);
        p2 <= addw(p2, m);
      end
      OP_P4: begin
        m  <= mulw(t1, dt);
        p1 <= addw(t1, q01);
        p2 <= addw(p2, q01);
        p3 <= addw(p3, q11);
      end
      OP_P5: t0 <= addw(t0, m);
      OP_P6: p0 <= addw(t0, q00);
      OP_P7: begin
        s <= addw(p0, rn);
        y <= subw(z, pos);
      end
      // gains
      OP_DIVB: k0 <= quo;
      OP_K1:   k1 <= quo;
      // correct
      OP_E0: m <= mulw(k0, y);
      OP_E1: begin
        pos <= addw(pos, m);
        m   <= mulw(k1, y);
      end
      OP_E2: begin
        vel <= addw(vel, m);
        m   <= mulw(k0, p0);
      end
      OP_E3: begin
        t0 <= subw(p0, m);
        m  <= mulw(k0, p1);
      end
      OP_E4: begin
        t1 <= subw(p1, m);
        m  <= mulw(k1, p0);
      end
      OP_E5: begin
        p2 <= subw(p2, m);
        m  <= mulw(k1, p1);
      end
      OP_E6: begin
        p3 <= subw(p3, m);
        p0 <= t0;
        p1 <= t1;
      end
      OP_OUT: begin
        est.position <= out32(pos);
        est.velocity <= out32(vel);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/kpvf_ctrl.sv =====
// filter sequencer: handshakes and micro-operation order
module kpvf_ctrl import kpvf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    meas_valid,
  output logic                    meas_ready,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  output logic                    est_valid,
  input  logic                    est_ready,
  output dp_cmd_t                 cmd,
  input  dp_status_t              status
);

  state_t state, state_next;
  logic   est_load;
  logic   cfg_known;

  assign cfg_ready  = (state == ST_IDLE);
  assign meas_ready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_known  = (cfg_index <= REG_MEAS_NOISE);
  assign est_load   = (state == ST_FIN) && (!est_valid || est_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          state_next = cfg_known ? ST_N0 : ST_IDLE;
        end else if (meas_valid) begin
          state_next = ST_SEL;
        end
      end
      ST_N0: state_next = ST_N1;
      ST_N1: state_next = ST_N2;
      ST_N2: state_next = ST_N3;
      ST_N3: state_next = ST_N4;
      ST_N4: state_next = ST_N5;
      ST_N5: state_next = ST_N6;
      ST_N6: state_next = ST_IDLE;
      ST_SEL: state_next = status.load_req ? ST_FIN : ST_P1;
      ST_P1: state_next = ST_P2;
      ST_P2: state_next = ST_P3;
      ST_P3: state_next = ST_P4;
      ST_P4: state_next = ST_P5;
      ST_P5: state_next = ST_P6;
      ST_P6: state_next = ST_P7;
      ST_P7: state_next = ST_SCHK;
      ST_SCHK: state_next = status.s_zero ? ST_FIN : ST_DIV0;
      ST_DIV0: state_next = status.div_done ? ST_DIV1 : ST_DIV0;
      ST_DIV1: state_next = status.div_done ? ST_E0 : ST_DIV1;
      ST_E0: state_next = ST_E1;
      ST_E1: state_next = ST_E2;
      ST_E2: state_next = ST_E3;
      ST_E3: state_next = ST_E4;
      ST_E4: state_next = ST_E5;
      ST_E5: state_next = ST_E6;
      ST_E6: state_next = ST_FIN;
      ST_FIN: state_next = est_load ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.op = OP_CFG;
        end else if (meas_valid) begin
          cmd.op = OP_CAPTURE;
        end
      end
      ST_N0: cmd.op = OP_N0;
      ST_N1: cmd.op = OP_N1;
      ST_N2: cmd.op = OP_N2;
      ST_N3: cmd.op = OP_N3;
      ST_N4: cmd.op = OP_N4;
      ST_N5: cmd.op = OP_N5;
      ST_N6: cmd.op = OP_N6;
      ST_SEL: cmd.op = status.load_req ? OP_LOAD : OP_P0;
      ST_P1: cmd.op = OP_P1;
      ST_P2: cmd.op = OP_P2;
      ST_P3: cmd.op = OP_P3;
      ST_P4: cmd.op = OP_P4;
      ST_P5: cmd.op = OP_P5;
      ST_P6: cmd.op = OP_P6;
      ST_P7: cmd.op = OP_P7;
      ST_SCHK: cmd.op = status.s_zero ? OP_NONE : OP_DIVA;
      ST_DIV0: cmd.op = status.div_done ? OP_DIVB : OP_NONE;
      ST_DIV1: cmd.op = status.div_done ? OP_K1 : OP_NONE;
      ST_E0: cmd.op = OP_E0;
      ST_E1: cmd.op = OP_E1;
      ST_E2: cmd.op = OP_E2;
      ST_E3: cmd.op = OP_E3;
      ST_E4: cmd.op = OP_E4;
      ST_E5: cmd.op = OP_E5;
      ST_E6: cmd.op = OP_E6;
      ST_FIN: cmd.op = est_load ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state and result valid flag; reset derives the noise terms first
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_N0;
      est_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (est_load) begin
        est_valid <= 1'b1;
      end else if (est_ready) begin
        est_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_derives: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_known |=> state == ST_N0)
    else $error("register write did not start noise derivation");
  a_item_starts: assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas_ready |=> state == ST_SEL)
    else $error("accepted transaction did not start processing");
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    !(meas_valid && meas_ready && cfg_valid && cfg_ready))
    else $error("item and register write accepted together");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(est_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside finish state");
`endif

endmodule

// ===== src/kalman_position_velocity_filter.sv =====
// top level of the two-state constant-velocity kalman filter
//
// channels: meas (start_req, sample) in, est (position, velocity) out, both
// valid/ready; a transaction moves at a clock edge where valid and ready are high.
// cfg writes register cfg_index (0 time_step, 1 process_noise, 2 measurement_noise)
// with cfg_data; a write re-derives the noise terms (steps N0 to N6) and clears the filter
// so the next sample loads the state. unknown indexes are dropped.
// a loading sample loads the state from it and then has its result registered. a
// tracking sample runs the predict steps, then the two gain divisions through the
// single restoring divider, one quotient bit per cycle, then the correct steps, one
// product per cycle; a zero innovation variance s skips the divisions and correction.
// one sample is in work at a time; the next can be taken only once the sequencer is
// back in idle after the result is registered, and a pending cfg write goes first.
// reset (rst, synchronous) loads default registers and derives the noise terms (steps
// N0 to N6) before meas_ready and cfg_ready rise.
// if the receiver stalls, the result stays in the output register, a new sample may
// still be taken, and its result waits until the older one has been taken.
module kalman_position_velocity_filter import kpvf_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    meas_valid,
  output logic                    meas_ready,
  input  meas_t                   meas,
  output logic                    est_valid,
  input  logic                    est_ready,
  output est_t                    est,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  kpvf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .est_valid  (est_valid),
    .est_ready  (est_ready),
    .cmd        (cmd),
    .status     (status)
  );

  // arithmetic and state
  kpvf_dp #(.W(WORD_BITS), .F(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .meas      (meas),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .est       (est)
  );

endmodule
